// ===== hdl/lkos_pkg.sv =====
// ============================================================================
// lkos_pkg
// Shared types, codes and helpers for the looping keyframe offset sampler.
// ============================================================================
package lkos_pkg;

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 2'd2;

    // Axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // Rate arithmetic: Q1.16 rate, 1.0 is 2^16
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned RATE_W    = FRAC_BITS + 1;
    localparam logic [RATE_W-1:0] RATE_ONE = 17'h10000;
    // signed width of rate numerator and denominator (loop span reaches ~98k)
    localparam int unsigned DIV_W     = 19;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } xyz_t;

    typedef struct packed {
        logic signed [15:0] frame;
        xyz_t               off;
    } key_t;

    typedef struct packed {
        logic signed [DIV_W-1:0] num;
        logic signed [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         key_slot;
        logic signed [15:0] key_frame_no;
        logic signed [31:0] key_off_x;
        logic signed [31:0] key_off_y;
        logic signed [31:0] key_off_z;
        logic signed [15:0] query_frame;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } rsp_t;

    // Pick one axis of an offset
    function automatic logic signed [31:0] sel_axis(input xyz_t v, input logic [1:0] ax);
        logic signed [31:0] r;
        case (ax)
            AX_X:    r = v.x;
            AX_Y:    r = v.y;
            AX_Z:    r = v.z;
            default: r = v.x;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/lkos_key_store.sv =====
// ============================================================================
// lkos_key_store
// Keyframe table: one write port, one read port with registered read data.
// ============================================================================
module lkos_key_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  lkos_pkg::key_t       wr_key,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output lkos_pkg::key_t       rd_key
);

    lkos_pkg::key_t mem [DEPTH];
    lkos_pkg::key_t rd_key_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_key;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg <= mem[rd_addr];
        end
    end

    assign rd_key = rd_key_reg;

endmodule

// ===== hdl/lkos_rate_div.sv =====
// ============================================================================
// lkos_rate_div
// Q1.16 rate num/den clamped to [0,1]; restoring divider, one bit per cycle.
// ============================================================================
module lkos_rate_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  lkos_pkg::div_req_t              req,
    output logic                            done,
    output logic [lkos_pkg::RATE_W-1:0]     rate
);

    localparam int unsigned UW = lkos_pkg::DIV_W - 1;    // unsigned magnitude width
    localparam int unsigned CW = $clog2(lkos_pkg::FRAC_BITS + 1);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [CW-1:0]                      cnt_reg, cnt_next;
    logic [UW-1:0]                      rem_reg, rem_next;
    logic [UW-1:0]                      den_reg, den_next;
    logic [lkos_pkg::RATE_W-1:0]        rate_reg, rate_next;
    logic [UW:0]                        trial;
    logic [UW:0]                        diff;

    // one quotient bit: shift remainder, try subtract
    assign trial = {rem_reg, 1'b0};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rate_next = rate_reg;
        if (start)
        begin
            den_next = req.den[UW-1:0];
            rem_next = req.num[UW-1:0];
            cnt_next = CW'(lkos_pkg::FRAC_BITS);
            if (req.num <= 0 || req.den <= 0)
            begin
                rate_next = '0;
                done_next = 1'b1;
            end
            else if (req.num >= req.den)
            begin
                rate_next = lkos_pkg::RATE_ONE;
                done_next = 1'b1;
            end
            else
            begin
                rate_next = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!diff[UW])
            begin
                rem_next  = diff[UW-1:0];
                rate_next = {rate_reg[lkos_pkg::RATE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[UW-1:0];
                rate_next = {rate_reg[lkos_pkg::RATE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        rate_reg <= rate_next;
    end

    assign done = done_reg;
    assign rate = rate_reg;

endmodule

// ===== hdl/lkos_blend.sv =====
// ============================================================================
// lkos_blend
// a + trunc((b - a) * rate / 2^16) per axis; one shared multiplier, three
// stages (difference, product, sum), axes issued on successive cycles.
// ============================================================================
module lkos_blend (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  lkos_pkg::xyz_t                  a,
    input  lkos_pkg::xyz_t                  b,
    input  logic [lkos_pkg::RATE_W-1:0]     rate,
    output logic                            done,
    output lkos_pkg::xyz_t                  res
);

    localparam int unsigned PW = 33 + lkos_pkg::RATE_W;

    logic               run_reg, run_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               v0_reg, v1_reg, done_reg;
    logic [1:0]         ax0_reg, ax1_reg;
    logic               neg0_reg, neg1_reg;
    logic [32:0]        mag_reg;
    logic [32:0]        part_reg;
    lkos_pkg::xyz_t     res_reg;

    logic signed [31:0] a_s0, b_s0, a_s2;
    logic signed [32:0] diff;
    logic [PW-1:0]      prod;
    logic [32:0]        a_ext, sum;

    // axis issue counter
    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = lkos_pkg::AX_X;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == lkos_pkg::AX_Z)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            v0_reg   <= run_reg;
            v1_reg   <= v0_reg;
            done_reg <= v1_reg && (ax1_reg == lkos_pkg::AX_Z);
        end
    end

    // stage 0: signed difference, split into sign and magnitude
    assign a_s0 = lkos_pkg::sel_axis(a, cnt_reg);
    assign b_s0 = lkos_pkg::sel_axis(b, cnt_reg);
    assign diff = {b_s0[31], b_s0} - {a_s0[31], a_s0};

    // stage 1: magnitude times rate
    assign prod = PW'(mag_reg) * PW'(rate);

    // stage 2: move a toward b
    assign a_s2  = lkos_pkg::sel_axis(a, ax1_reg);
    assign a_ext = {a_s2[31], a_s2};
    assign sum   = neg1_reg ? (a_ext - part_reg) : (a_ext + part_reg);

    always_ff @(posedge clk)
    begin
        ax0_reg  <= cnt_reg;
        neg0_reg <= diff[32];
        mag_reg  <= diff[32] ? 33'(-diff) : 33'(diff);
        ax1_reg  <= ax0_reg;
        neg1_reg <= neg0_reg;
        part_reg <= prod[lkos_pkg::FRAC_BITS +: 33];
        if (v1_reg)
        begin
            case (ax1_reg)
                lkos_pkg::AX_X: res_reg.x <= sum[31:0];
                lkos_pkg::AX_Y: res_reg.y <= sum[31:0];
                lkos_pkg::AX_Z: res_reg.z <= sum[31:0];
                default:        res_reg.x <= res_reg.x;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== hdl/looping_keyframe_offset_sampler_top.sv =====
// ============================================================================
// looping_keyframe_offset_sampler_top
// Keyframe table with a scanning query engine: finds the bracketing keys,
// divides out a Q1.16 rate and blends the three offset axes.
// ============================================================================
//
//  channel | signals                          | beat
//  --------+----------------------------------+---------------------------------
//  req     | req_valid/req_ready, req_data    | key write or offset query
//  rsp     | rsp_valid/rsp_ready, rsp_data    | one offset per query
//  cfg     | cfg_valid/cfg_ready, cfg_index,  | register write, always ready
//          | cfg_data                         |
//
//  A query scans the key table (one table read per cycle) until it finds the
//  bracketing keys, then runs the rate divider and then the shared blend
//  multiplier over the three axes.
//  One request is in flight at a time; a finished offset sits in the output
//  register while the next request is taken. Reset clears control and sets the
//  configuration registers to their defaults; the key table is not cleared.
//
module looping_keyframe_offset_sampler_top #(
    parameter int MAX_KEYS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  lkos_pkg::req_t                      req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output lkos_pkg::rsp_t                      rsp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lkos_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lkos_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int DW = lkos_pkg::DIV_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_BLEND = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;

    // configuration
    logic [4:0]             key_count_reg;
    logic                   loop_mode_reg;
    logic [14:0]            total_frames_reg;
    logic [NW-1:0]          n_keys;

    // query context
    logic signed [15:0]     qframe_reg;
    logic                   zero_reg;
    logic                   prev_vld_reg, next_vld_reg;
    lkos_pkg::key_t         prev_key_reg, next_key_reg, first_key_reg;
    lkos_pkg::xyz_t         a_reg, b_reg, a_next, b_next;

    // scan control
    logic [NW-1:0]          issue_reg;
    logic                   rd_vld_reg;
    logic [AW-1:0]          rd_idx_reg;
    logic                   issue, scan_hit, scan_last, scan_done;

    // table ports
    logic                   wr_en;
    logic [31:0]            slot_w;
    lkos_pkg::key_t         wr_key, rd_key;

    // accepted request
    logic                   req_fire, query_fire;

    // rate and blend
    lkos_pkg::div_req_t     div_req;
    logic                   div_done;
    logic [lkos_pkg::RATE_W-1:0] rate;
    logic                   blend_start, blend_done;
    lkos_pkg::xyz_t         blend_res;

    // output register
    logic                   rsp_valid_reg, rsp_valid_next;
    lkos_pkg::rsp_t         rsp_data_reg;
    logic                   rsp_load;

    // setup scratch
    logic signed [DW-1:0]   tf_eff, span;

    assign req_ready  = (state_reg == ST_IDLE);
    assign req_fire   = req_valid && req_ready;
    assign query_fire = req_fire && (req_data.req_type == lkos_pkg::REQ_QUERY);
    assign cfg_ready  = 1'b1;

    // key count limited to table depth
    always_comb
    begin
        if (32'(key_count_reg) > 32'(MAX_KEYS))
        begin
            n_keys = NW'(MAX_KEYS);
        end
        else
        begin
            n_keys = NW'(key_count_reg);
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg    <= '0;
            loop_mode_reg    <= 1'b0;
            total_frames_reg <= 15'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lkos_pkg::CFG_KEY_COUNT:    key_count_reg    <= cfg_data[4:0];
                lkos_pkg::CFG_LOOP_MODE:    loop_mode_reg    <= cfg_data[0];
                lkos_pkg::CFG_TOTAL_FRAMES: total_frames_reg <= cfg_data[14:0];
                default:                    key_count_reg    <= key_count_reg;
            endcase
        end
    end

    // key write path
    assign slot_w = 32'(req_data.key_slot);
    assign wr_en  = req_fire && (req_data.req_type == lkos_pkg::REQ_WRITE)
                    && (slot_w < 32'(MAX_KEYS));
    assign wr_key = '{frame: req_data.key_frame_no,
                      off:   '{x: req_data.key_off_x,
                               y: req_data.key_off_y,
                               z: req_data.key_off_z}};

    lkos_key_store #(
        .DEPTH (MAX_KEYS),
        .AW    (AW)
    ) u_key_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_w[AW-1:0]),
        .wr_key  (wr_key),
        .rd_en   (issue),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_key  (rd_key)
    );

    // scan: one read issued per cycle, returned entry checked once the registered read data arrives
    assign scan_hit  = rd_vld_reg && (rd_key.frame >= qframe_reg);
    assign scan_last = rd_vld_reg && ((NW'(rd_idx_reg) + NW'(1)) == n_keys);
    assign scan_done = scan_hit || scan_last;
    assign issue     = (state_reg == ST_SCAN) && (issue_reg < n_keys) && !scan_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            prev_vld_reg <= 1'b0;
            next_vld_reg <= 1'b0;
            zero_reg     <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= issue;
            if (query_fire)
            begin
                issue_reg    <= '0;
                prev_vld_reg <= 1'b0;
                next_vld_reg <= 1'b0;
                zero_reg     <= (n_keys == '0) || (req_data.query_frame < 0);
            end
            else
            begin
                if (issue)
                begin
                    issue_reg <= issue_reg + NW'(1);
                end
                if ((state_reg == ST_SCAN) && rd_vld_reg)
                begin
                    if (rd_key.frame <= qframe_reg)
                    begin
                        prev_vld_reg <= 1'b1;
                    end
                    if (scan_hit)
                    begin
                        next_vld_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // captured keys and query frame
    always_ff @(posedge clk)
    begin
        if (query_fire)
        begin
            qframe_reg <= req_data.query_frame;
        end
        if (issue)
        begin
            rd_idx_reg <= issue_reg[AW-1:0];
        end
        if ((state_reg == ST_SCAN) && rd_vld_reg)
        begin
            if (rd_key.frame <= qframe_reg)
            begin
                prev_key_reg <= rd_key;
            end
            if (scan_hit)
            begin
                next_key_reg <= rd_key;
            end
            if (rd_idx_reg == '0)
            begin
                first_key_reg <= rd_key;
            end
        end
        if (state_reg == ST_SETUP)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // setup: pick endpoints and rate operands from the scan outcome
    assign tf_eff = (total_frames_reg == '0) ? DW'(1) : $signed(DW'(total_frames_reg));
    assign span   = tf_eff - DW'(prev_key_reg.frame) + DW'(first_key_reg.frame);

    always_comb
    begin
        a_next      = '0;
        b_next      = '0;
        div_req.num = '0;
        div_req.den = '0;
        if (zero_reg)
        begin
            a_next = '0;
        end
        else if (!prev_vld_reg && next_vld_reg)
        begin
            // before the first key: rise from zero
            if (next_key_reg.frame <= 0)
            begin
                a_next = next_key_reg.off;
            end
            else
            begin
                b_next      = next_key_reg.off;
                div_req.num = DW'(qframe_reg);
                div_req.den = DW'(next_key_reg.frame);
            end
        end
        else if (prev_vld_reg && !next_vld_reg)
        begin
            // past the last key: wrap toward key 0 or hold
            a_next = prev_key_reg.off;
            if (loop_mode_reg && (span > 0))
            begin
                b_next      = first_key_reg.off;
                div_req.num = DW'(qframe_reg) - DW'(prev_key_reg.frame);
                div_req.den = span;
            end
        end
        else if (prev_vld_reg)
        begin
            a_next = prev_key_reg.off;
            if (prev_key_reg.frame != next_key_reg.frame)
            begin
                b_next      = next_key_reg.off;
                div_req.num = DW'(qframe_reg) - DW'(prev_key_reg.frame);
                div_req.den = DW'(next_key_reg.frame) - DW'(prev_key_reg.frame);
            end
        end
    end

    lkos_rate_div u_rate_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_SETUP),
        .req   (div_req),
        .done  (div_done),
        .rate  (rate)
    );

    assign blend_start = (state_reg == ST_DIV) && div_done;

    lkos_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .start (blend_start),
        .a     (a_reg),
        .b     (b_reg),
        .rate  (rate),
        .done  (blend_done),
        .res   (blend_res)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_fire)
                begin
                    if ((n_keys == '0) || (req_data.query_frame < 0))
                    begin
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                if (blend_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // output register
    assign rsp_load = (state_reg == ST_OUT) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_data_reg <= '{out_x: blend_res.x, out_y: blend_res.y, out_z: blend_res.z};
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // checks
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        query_fire |=> !req_ready)
        else $error("request taken while a query is in flight");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("rate divider finished outside its wait state");

    a_blend_in_blend: assert property (@(posedge clk) disable iff (!rst_n)
        blend_done |-> (state_reg == ST_BLEND))
        else $error("blend finished outside its wait state");

    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_OUT))
        else $error("response raised without a finished query");

endmodule
